FILE: rtl/rc4_pkg.sv
// ----------------------------------------------------------------------------
// rc4_pkg
// Shared types and constants of the RC4 engine: function codes, sequencer
// states, the result word and the key store control group.
// ----------------------------------------------------------------------------
package rc4_pkg;

  localparam int SBOX_ENTRIES            = 256;
  localparam int SBOX_AW                 = $clog2(SBOX_ENTRIES);
  localparam int KEY_STORE_DEPTH_DEFAULT = 256;
  localparam int KEY_LEN_W               = 9;
  localparam logic [KEY_LEN_W-1:0] KEY_LEN_RESET = 9'd16;

  typedef logic [7:0]         byte_t;
  typedef logic [SBOX_AW-1:0] sbox_addr_t;

  typedef enum logic [1:0] {
    FUNC_LOAD  = 2'd0,
    FUNC_SCHED = 2'd1,
    FUNC_CRYPT = 2'd2
  } func_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INIT,
    ST_KS_A,
    ST_KS_B,
    ST_KS_C,
    ST_KS_D,
    ST_DONE,
    ST_CR_J,
    ST_CR_T,
    ST_CR_W
  } state_t;

  typedef struct packed {
    byte_t out_byte;
    logic  last_out;
    logic  sched_done;
  } out_word_t;

  typedef struct packed {
    logic  wr_en;
    byte_t wr_index;
    byte_t wr_data;
    logic  restart;
    logic  advance;
  } key_ctl_t;

endpackage

FILE: rtl/rc4_if.sv
// ----------------------------------------------------------------------------
// rc4 channel interfaces
// Valid/ready channels of the RC4 engine: input words, result words and the
// key length write channel.
// ----------------------------------------------------------------------------
interface rc4_in_if;
  import rc4_pkg::*;

  logic       valid;
  logic       ready;
  logic [1:0] func;
  byte_t      key_index;
  byte_t      key_byte;
  byte_t      data_byte;
  logic       last_in;

  modport source (output valid, func, key_index, key_byte, data_byte, last_in,
                  input ready);
  modport sink   (input valid, func, key_index, key_byte, data_byte, last_in,
                  output ready);
endinterface

interface rc4_out_if;
  import rc4_pkg::*;

  logic  valid;
  logic  ready;
  byte_t out_byte;
  logic  last_out;
  logic  sched_done;

  modport source (output valid, out_byte, last_out, sched_done, input ready);
  modport sink   (input valid, out_byte, last_out, sched_done, output ready);
endinterface

interface rc4_cfg_if;
  import rc4_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [KEY_LEN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

FILE: rtl/rc4_key_store.sv
// ----------------------------------------------------------------------------
// rc4_key_store
// Key byte RAM with a registered read at the cyclic key position, which
// wraps at the effective key length during the key schedule.
// ----------------------------------------------------------------------------
module rc4_key_store #(
  parameter int KEY_STORE_DEPTH = rc4_pkg::KEY_STORE_DEPTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  rc4_pkg::key_ctl_t             ctl,
  input  logic [rc4_pkg::KEY_LEN_W-1:0] key_length,
  output rc4_pkg::byte_t                rd_data
);
  import rc4_pkg::*;

  localparam int KW = (KEY_STORE_DEPTH > 1) ? $clog2(KEY_STORE_DEPTH) : 1;
  localparam logic [KEY_LEN_W-1:0] DEPTH_L = KEY_LEN_W'(KEY_STORE_DEPTH);

  byte_t                key_mem [KEY_STORE_DEPTH];
  logic [KW-1:0]        key_pos;
  logic [KW-1:0]        key_pos_next;
  logic [KEY_LEN_W-1:0] eff_len;
  logic [KEY_LEN_W-1:0] pos_inc;
  logic                 wr_ok;

  assign eff_len = (key_length == '0 || key_length > DEPTH_L) ? DEPTH_L : key_length;
  assign pos_inc = KEY_LEN_W'(key_pos) + 1'b1;
  assign wr_ok   = ctl.wr_en && ({1'b0, ctl.wr_index} < DEPTH_L);

  always_comb begin
    if (ctl.restart) begin
      key_pos_next = '0;
    end else if (ctl.advance) begin
      key_pos_next = (pos_inc >= eff_len) ? '0 : pos_inc[KW-1:0];
    end else begin
      key_pos_next = key_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_pos <= '0;
    end else begin
      key_pos <= key_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      key_mem[ctl.wr_index[KW-1:0]] <= ctl.wr_data;
    end
    rd_data <= key_mem[key_pos];
  end

endmodule

FILE: rtl/rc4_stream_cipher_top.sv
// ----------------------------------------------------------------------------
// rc4_stream_cipher_top
// RC4 engine around a single-port-read, single-port-write permutation RAM.
// ----------------------------------------------------------------------------
// A load key byte word, or a word with the unused code, leaves the engine in
// ST_IDLE. A crypt byte word passes through ST_CR_J, ST_CR_T and ST_CR_W: its
// three dependent reads of the permutation RAM (sbox[i], sbox[j], sbox[a+b])
// share one read port, and the next word enters in the cycle of the final
// write. A key schedule word keeps the input stalled through the identity
// fill, the 256 swap steps (each through ST_KS_A to ST_KS_D) and the posting
// of the completion word. Results leave through a two-entry output queue; an
// input word is taken only while that queue is empty, or holds one word and
// is not being written in the same cycle.
// ----------------------------------------------------------------------------
module rc4_stream_cipher_top #(
  parameter int KEY_STORE_DEPTH = rc4_pkg::KEY_STORE_DEPTH_DEFAULT
) (
  input logic         clk,
  input logic         rst,
  rc4_in_if.sink      din,
  rc4_out_if.source   dout,
  rc4_cfg_if.sink     cfg
);
  import rc4_pkg::*;

  state_t               state;
  state_t               state_next;
  logic [KEY_LEN_W-1:0] key_length;

  byte_t                index_i;
  byte_t                index_j;
  byte_t                i_inc;
  sbox_addr_t           n;
  logic                 fwd_a;

  byte_t                a_val;
  byte_t                b_val;
  logic                 sel_i;
  logic                 sel_j;
  byte_t                data_hold;
  logic                 last_hold;

  byte_t                sbox [SBOX_ENTRIES];
  logic                 mem_we;
  sbox_addr_t           mem_waddr;
  byte_t                mem_wdata;
  sbox_addr_t           mem_raddr;
  byte_t                sbox_rdata;

  key_ctl_t             key_ctl;
  byte_t                key_rd;
  logic                 key_advance;

  byte_t                a_cur;
  byte_t                j_sched;
  byte_t                j_crypt;
  byte_t                t_addr;
  byte_t                ks;

  out_word_t            fifo_mem [2];
  logic                 wr_ptr;
  logic                 rd_ptr;
  logic [1:0]           fifo_cnt;
  logic                 push;
  logic                 pop;
  out_word_t            push_word;
  logic                 fifo_room;
  logic                 accept_state;
  logic                 accept;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      key_length <= KEY_LEN_RESET;
    end else if (cfg.valid && cfg.ready) begin
      key_length <= cfg.data;
    end
  end

  assign accept_state = (state == ST_IDLE) || (state == ST_CR_W);
  assign fifo_room    = (fifo_cnt == 2'd0) || (fifo_cnt == 2'd1 && !push);
  assign din.ready    = accept_state && fifo_room;
  assign accept       = din.valid && din.ready;

  assign i_inc   = index_i + 8'd1;
  assign a_cur   = fwd_a ? a_val : sbox_rdata;
  assign j_sched = index_j + key_rd + sbox_rdata;
  assign j_crypt = index_j + a_cur;
  assign t_addr  = a_val + sbox_rdata;
  assign ks      = sel_j ? a_val : (sel_i ? b_val : sbox_rdata);

  assign key_ctl.wr_en    = accept && (din.func == FUNC_LOAD);
  assign key_ctl.wr_index = din.key_index;
  assign key_ctl.wr_data  = din.key_byte;
  assign key_ctl.restart  = accept && (din.func == FUNC_SCHED);
  assign key_ctl.advance  = key_advance;

  rc4_key_store #(
    .KEY_STORE_DEPTH (KEY_STORE_DEPTH)
  ) u_key_store (
    .clk        (clk),
    .rst        (rst),
    .ctl        (key_ctl),
    .key_length (key_length),
    .rd_data    (key_rd)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE, ST_CR_W: begin
        state_next = ST_IDLE;
        if (accept) begin
          case (din.func)
            FUNC_SCHED: state_next = ST_INIT;
            FUNC_CRYPT: state_next = ST_CR_J;
            default:    state_next = ST_IDLE;
          endcase
        end
      end
      ST_INIT: state_next = (n == '1) ? ST_KS_A : ST_INIT;
      ST_KS_A: state_next = ST_KS_B;
      ST_KS_B: state_next = ST_KS_C;
      ST_KS_C: state_next = ST_KS_D;
      ST_KS_D: state_next = (n == '1) ? ST_DONE : ST_KS_A;
      ST_DONE: state_next = ST_IDLE;
      ST_CR_J: state_next = ST_CR_T;
      ST_CR_T: state_next = ST_CR_W;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    mem_we      = 1'b0;
    mem_waddr   = index_i;
    mem_wdata   = sbox_rdata;
    mem_raddr   = i_inc;
    key_advance = 1'b0;
    push        = 1'b0;
    push_word   = '0;
    case (state)
      ST_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = n;
        mem_wdata = n;
      end
      ST_KS_A: begin
        mem_raddr = n;
      end
      ST_KS_B: begin
        mem_raddr   = j_sched;
        key_advance = 1'b1;
      end
      ST_KS_C: begin
        mem_we    = 1'b1;
        mem_waddr = n;
        mem_wdata = sbox_rdata;
      end
      ST_KS_D: begin
        mem_we    = 1'b1;
        mem_waddr = index_j;
        mem_wdata = a_val;
      end
      ST_DONE: begin
        push                 = 1'b1;
        push_word.sched_done = 1'b1;
      end
      ST_CR_J: begin
        mem_raddr = j_crypt;
      end
      ST_CR_T: begin
        mem_we    = 1'b1;
        mem_waddr = index_i;
        mem_wdata = sbox_rdata;
        mem_raddr = t_addr;
      end
      ST_CR_W: begin
        mem_we             = 1'b1;
        mem_waddr          = index_j;
        mem_wdata          = a_val;
        push               = 1'b1;
        push_word.out_byte = data_hold ^ ks;
        push_word.last_out = last_hold;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index_i <= '0;
      index_j <= '0;
      n       <= '0;
      fwd_a   <= 1'b0;
    end else begin
      case (state)
        ST_INIT: n <= n + 1'b1;
        ST_KS_B: index_j <= j_sched;
        ST_KS_D: n <= n + 1'b1;
        ST_DONE: begin
          index_i <= '0;
          index_j <= '0;
        end
        ST_CR_J: begin
          index_j <= j_crypt;
          fwd_a   <= 1'b0;
        end
        default: begin
        end
      endcase
      if (accept) begin
        case (din.func)
          FUNC_SCHED: begin
            n       <= '0;
            index_j <= '0;
          end
          FUNC_CRYPT: begin
            index_i <= i_inc;
            fwd_a   <= (state == ST_CR_W) && (i_inc == index_j);
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_KS_B: a_val <= sbox_rdata;
      ST_CR_J: a_val <= a_cur;
      ST_CR_T: begin
        b_val <= sbox_rdata;
        sel_j <= (t_addr == index_j);
        sel_i <= (t_addr == index_i);
      end
      default: begin
      end
    endcase
    if (accept) begin
      data_hold <= din.data_byte;
      last_hold <= din.last_in;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      sbox[mem_waddr] <= mem_wdata;
    end
    sbox_rdata <= sbox[mem_raddr];
  end

  assign pop = dout.valid && dout.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr   <= 1'b0;
      rd_ptr   <= 1'b0;
      fifo_cnt <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10:   fifo_cnt <= fifo_cnt + 2'd1;
        2'b01:   fifo_cnt <= fifo_cnt - 2'd1;
        default: fifo_cnt <= fifo_cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fifo_mem[wr_ptr] <= push_word;
    end
  end

  assign dout.valid      = (fifo_cnt != 2'd0);
  assign dout.out_byte   = fifo_mem[rd_ptr].out_byte;
  assign dout.last_out   = fifo_mem[rd_ptr].last_out;
  assign dout.sched_done = fifo_mem[rd_ptr].sched_done;

  a_queue_room: assert property (@(posedge clk) disable iff (rst)
    push |-> (fifo_cnt != 2'd2))
    else $error("result pushed into a full output queue");

  a_queue_ptrs: assert property (@(posedge clk) disable iff (rst)
    ((fifo_cnt == 2'd0) || (fifo_cnt == 2'd2)) |-> (wr_ptr == rd_ptr))
    else $error("output queue pointers disagree with its count");

  a_i_step: assert property (@(posedge clk) disable iff (rst)
    (!rst && accept && (din.func == FUNC_CRYPT)) |=>
      (index_i == $past(index_i) + 8'd1))
    else $error("stream index i did not advance on a crypt word");

  a_sched_clear: assert property (@(posedge clk) disable iff (rst)
    (!rst && (state == ST_DONE)) |=> (index_i == 8'd0 && index_j == 8'd0))
    else $error("stream indices not cleared after the key schedule");

endmodule
